[design/mlfq_pkg.sv]
package mlfq_pkg;

	localparam int ID_W   = 4;
	localparam int SVC_W  = 12;
	localparam int LVL_W  = 2;
	localparam int TS_W   = 4;
	localparam int CFG_W  = 4;

	localparam logic [SVC_W-1:0] SAT_TICKS = 12'hFFF;
	localparam logic [SVC_W-1:0] SLICE_RST = 12'd2;
	localparam logic [TS_W-1:0]  TS_RST    = 4'd2;

	typedef enum logic [0:0] {
		CFG_TIME_SLICE = 1'b0,
		CFG_EXP_SLICES = 1'b1
	} cfg_idx_t;

	// One configuration word handed to the slice table.
	typedef struct packed {
		logic             wr;
		cfg_idx_t         idx;
		logic [CFG_W-1:0] data;
	} cfg_wr_t;

endpackage

[design/mlfq_ram.sv]
module mlfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/mlfq_slice_calc.sv]
module mlfq_slice_calc
	import mlfq_pkg::*;
#(
	parameter int NUM_LEVELS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cfg_wr_t                           cfg,
	output logic                              busy,
	output logic [NUM_LEVELS-1:0][SVC_W-1:0]  slices
);

	localparam int LW = $clog2(NUM_LEVELS);

	logic [TS_W-1:0]                  ts_q;
	logic                             exp_q;
	logic                             calc_q;
	logic [LW-1:0]                    lv_q;
	logic [SVC_W-1:0]                 pow_q;
	logic [NUM_LEVELS-1:0][SVC_W-1:0] slices_q;
	logic [SVC_W+TS_W-1:0]            prod;

	assign prod   = (SVC_W+TS_W)'(pow_q) * (SVC_W+TS_W)'(ts_q);
	assign busy   = calc_q;
	assign slices = slices_q;

	// Each write restarts a walk over the levels, one level per cycle,
	// building saturated base-slice powers, or the flat base slice.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q     <= TS_RST;
			exp_q    <= 1'b0;
			calc_q   <= 1'b0;
			lv_q     <= '0;
			pow_q    <= SVC_W'(1);
			slices_q <= {NUM_LEVELS{SLICE_RST}};
		end else if (cfg.wr) begin
			case (cfg.idx)
				CFG_TIME_SLICE: ts_q  <= TS_W'(cfg.data);
				CFG_EXP_SLICES: exp_q <= cfg.data[0];
				default: ;
			endcase
			calc_q <= 1'b1;
			lv_q   <= '0;
			pow_q  <= SVC_W'(1);
		end else if (calc_q) begin
			slices_q[lv_q] <= exp_q ? pow_q : SVC_W'(ts_q);
			pow_q          <= (prod > (SVC_W+TS_W)'(SAT_TICKS)) ? SAT_TICKS : prod[SVC_W-1:0];
			if (lv_q == LW'(NUM_LEVELS - 1)) begin
				calc_q <= 1'b0;
			end else begin
				lv_q <= lv_q + LW'(1);
			end
		end
	end

endmodule

[design/mlfq_tick_scheduler_top.sv]
// Channel   Handshake                   Word
// input     start / busy                mode, job_id, service_time
// result    done (one-cycle strobe)     ran_valid, ran_id, ran_level, job_finished,
//                                       job_requeued, requeue_level
// config    cfg_valid / cfg_ready       cfg_index, cfg_data
//
// An arrival is written into the queue and job memories at the edge that accepts it,
// so busy never rises for it. A tick on a running job passes through ST_JOB (job
// memory read, then update); one that must dispatch a job first passes through ST_SLOT
// and ST_JOB (queue slot read, job memory read, update). An idle tick reports in the
// next cycle. Both memories have registered reads. A config write keeps busy high
// while the slice table is rebuilt. Reset is asynchronous and clears the control
// state only; the receiver cannot stall results.
module mlfq_tick_scheduler_top
	import mlfq_pkg::*;
#(
	parameter int NUM_LEVELS = 4,
	parameter int MAX_JOBS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             mode,
	input  logic [ID_W-1:0]  job_id,
	input  logic [SVC_W-1:0] service_time,
	output logic             done,
	output logic             ran_valid,
	output logic [ID_W-1:0]  ran_id,
	output logic [LVL_W-1:0] ran_level,
	output logic             job_finished,
	output logic             job_requeued,
	output logic [LVL_W-1:0] requeue_level,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int LW  = $clog2(NUM_LEVELS);
	localparam int JW  = $clog2(MAX_JOBS);
	localparam int CW  = $clog2(MAX_JOBS + 1);
	localparam int SAW = $clog2(NUM_LEVELS * MAX_JOBS);

	typedef enum logic [1:0] {ST_IDLE, ST_SLOT, ST_JOB} state_t;

	function automatic logic [SAW-1:0] slot_addr(input logic [LW-1:0] lv,
		input logic [JW-1:0] idx);
		return SAW'(lv) * SAW'(MAX_JOBS) + SAW'(idx);
	endfunction

	state_t                           state_q;
	logic [JW-1:0]                    heads_q [NUM_LEVELS];
	logic [CW-1:0]                    counts_q [NUM_LEVELS];
	logic                             run_valid_q;
	logic [JW-1:0]                    run_id_q;
	logic [LW-1:0]                    run_level_q;
	logic [SVC_W-1:0]                 slice_used_q;

	logic                             calc_busy;
	logic [NUM_LEVELS-1:0][SVC_W-1:0] slices;
	cfg_wr_t                          cfg_wr;

	logic                             accept, arrive, tick, arrive_ok;
	logic [JW-1:0]                    jid;
	logic                             pick_found;
	logic [LW-1:0]                    pick_lv;
	logic                             any_queued;
	logic [JW-1:0]                    head0_dec;
	logic [JW-1:0]                    pick_head_inc;

	logic                             slot_we;
	logic [SAW-1:0]                   slot_waddr, slot_raddr;
	logic [JW-1:0]                    slot_wdata, slot_rdata;
	logic                             job_we;
	logic [JW-1:0]                    job_waddr, job_raddr;
	logic [2*SVC_W-1:0]               job_wdata, job_rdata;

	logic [SVC_W-1:0]                 svc, served_n, used_n;
	logic                             fin, expired, room;
	logic [LW-1:0]                    tgt;
	logic [JW:0]                      rear_sum;
	logic [JW-1:0]                    rear_pos;

	assign busy      = (state_q != ST_IDLE) || calc_busy;
	assign accept    = start && !busy;
	assign arrive    = accept && !mode;
	assign tick      = accept && mode;
	assign arrive_ok = arrive && (counts_q[0] < CW'(MAX_JOBS));
	assign cfg_ready = !calc_busy;

	assign cfg_wr.wr   = cfg_valid && cfg_ready;
	assign cfg_wr.idx  = cfg_idx_t'(cfg_index);
	assign cfg_wr.data = cfg_data;

	// Job ids fold onto the job table through a small constant table.
	always_comb begin
		jid = '0;
		for (int i = 0; i < (1 << ID_W); i++) begin
			if (job_id == ID_W'(i)) begin
				jid = JW'(i % MAX_JOBS);
			end
		end
	end

	always_comb begin
		pick_found = 1'b0;
		pick_lv    = '0;
		any_queued = 1'b0;
		for (int lv = NUM_LEVELS - 1; lv >= 0; lv--) begin
			if (counts_q[lv] != '0) begin
				pick_found = 1'b1;
				pick_lv    = LW'(lv);
				any_queued = 1'b1;
			end
		end
	end

	assign head0_dec     = (heads_q[0] == '0) ? JW'(MAX_JOBS - 1) : heads_q[0] - JW'(1);
	assign pick_head_inc = (heads_q[pick_lv] == JW'(MAX_JOBS - 1)) ? '0
		: heads_q[pick_lv] + JW'(1);

	// Update of the running job, valid while the job memory word is on rdata.
	assign svc      = job_rdata[2*SVC_W-1:SVC_W];
	assign served_n = (job_rdata[SVC_W-1:0] == SAT_TICKS) ? SAT_TICKS
		: job_rdata[SVC_W-1:0] + SVC_W'(1);
	assign used_n   = (slice_used_q == SAT_TICKS) ? SAT_TICKS : slice_used_q + SVC_W'(1);
	assign fin      = served_n >= svc;
	assign expired  = used_n >= slices[run_level_q];
	assign tgt      = (any_queued && run_level_q != LW'(NUM_LEVELS - 1))
		? run_level_q + LW'(1) : run_level_q;
	assign room     = counts_q[tgt] < CW'(MAX_JOBS);
	assign rear_sum = (JW+1)'(heads_q[tgt]) + (JW+1)'(counts_q[tgt]);
	assign rear_pos = (rear_sum >= (JW+1)'(MAX_JOBS)) ? JW'(rear_sum - (JW+1)'(MAX_JOBS))
		: JW'(rear_sum);

	// Only one item is in flight and busy is the interlock; the job memory is still read
	// and written at the same entry in the same cycle while in ST_JOB.
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = slot_addr('0, head0_dec);
		slot_wdata = jid;
		if (state_q == ST_JOB) begin
			slot_we    = !fin && expired && room;
			slot_waddr = slot_addr(tgt, rear_pos);
			slot_wdata = run_id_q;
		end else begin
			slot_we = arrive_ok;
		end
	end

	assign slot_raddr = slot_addr(pick_lv, heads_q[pick_lv]);

	always_comb begin
		job_we    = arrive_ok;
		job_waddr = jid;
		job_wdata = {service_time, {SVC_W{1'b0}}};
		if (state_q == ST_JOB) begin
			job_we    = 1'b1;
			job_waddr = run_id_q;
			job_wdata = {svc, served_n};
		end
	end

	assign job_raddr = (state_q == ST_SLOT) ? slot_rdata : run_id_q;

	mlfq_ram #(
		.WIDTH(JW),
		.DEPTH(NUM_LEVELS * MAX_JOBS)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.raddr(slot_raddr),
		.rdata(slot_rdata)
	);

	mlfq_ram #(
		.WIDTH(2 * SVC_W),
		.DEPTH(MAX_JOBS)
	) u_job_ram (
		.clk  (clk),
		.we   (job_we),
		.waddr(job_waddr),
		.wdata(job_wdata),
		.raddr(job_raddr),
		.rdata(job_rdata)
	);

	mlfq_slice_calc #(
		.NUM_LEVELS(NUM_LEVELS)
	) u_slice_calc (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_wr),
		.busy  (calc_busy),
		.slices(slices)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			run_valid_q   <= 1'b0;
			run_id_q      <= '0;
			run_level_q   <= '0;
			slice_used_q  <= '0;
			done          <= 1'b0;
			ran_valid     <= 1'b0;
			ran_id        <= '0;
			ran_level     <= '0;
			job_finished  <= 1'b0;
			job_requeued  <= 1'b0;
			requeue_level <= '0;
			for (int lv = 0; lv < NUM_LEVELS; lv++) begin
				heads_q[lv]  <= '0;
				counts_q[lv] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					// An idle tick reports straight from ST_IDLE; every other tick reports from ST_JOB.
					done <= tick && !run_valid_q && !pick_found;
					if (arrive_ok) begin
						heads_q[0]  <= head0_dec;
						counts_q[0] <= counts_q[0] + CW'(1);
					end
					if (tick) begin
						if (run_valid_q) begin
							state_q <= ST_JOB;
						end else if (pick_found) begin
							heads_q[pick_lv]  <= pick_head_inc;
							counts_q[pick_lv] <= counts_q[pick_lv] - CW'(1);
							run_valid_q       <= 1'b1;
							run_level_q       <= pick_lv;
							slice_used_q      <= '0;
							state_q           <= ST_SLOT;
						end else begin
							ran_valid     <= 1'b0;
							ran_id        <= '0;
							ran_level     <= '0;
							job_finished  <= 1'b0;
							job_requeued  <= 1'b0;
							requeue_level <= '0;
						end
					end
				end
				ST_SLOT: begin
					done     <= 1'b0;
					run_id_q <= slot_rdata;
					state_q  <= ST_JOB;
				end
				ST_JOB: begin
					done          <= 1'b1;
					ran_valid     <= 1'b1;
					ran_id        <= ID_W'(run_id_q);
					ran_level     <= LVL_W'(run_level_q);
					job_finished  <= fin;
					job_requeued  <= !fin && expired && room;
					requeue_level <= (!fin && expired && room) ? LVL_W'(tgt) : '0;
					if (fin || expired) begin
						run_valid_q  <= 1'b0;
						slice_used_q <= '0;
					end else begin
						slice_used_q <= used_n;
					end
					if (!fin && expired && room) begin
						counts_q[tgt] <= counts_q[tgt] + CW'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					done    <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fin_req_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(job_finished && job_requeued))
		else $error("job both finished and requeued");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ran_valid) |-> (!job_finished && !job_requeued && requeue_level == '0))
		else $error("idle tick carries job fields");

	a_run_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && run_valid_q) |=> ##1 done)
		else $error("tick on a running job did not report in two cycles");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		counts_q[0] <= CW'(MAX_JOBS))
		else $error("top queue count overflow");
`endif

endmodule

[verif/mlfq_tick_scheduler_checker.sv]
package mlfq_tick_tb_pkg;

	typedef enum logic {
		MODE_ARRIVAL = 1'b0,
		MODE_TICK    = 1'b1
	} mode_t;

endpackage

module mlfq_tick_scheduler_checker
	import mlfq_pkg::*;
	import mlfq_tick_tb_pkg::*;
#(
	parameter int NUM_LEVELS = 4,
	parameter int MAX_JOBS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             mode,
	input  logic [ID_W-1:0]  job_id,
	input  logic [SVC_W-1:0] service_time,
	input  logic             done,
	input  logic             ran_valid,
	input  logic [ID_W-1:0]  ran_id,
	input  logic [LVL_W-1:0] ran_level,
	input  logic             job_finished,
	input  logic             job_requeued,
	input  logic [LVL_W-1:0] requeue_level,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             ran;
		logic [ID_W-1:0]  id;
		logic [LVL_W-1:0] lvl;
		logic             fin;
		logic             req;
		logic [LVL_W-1:0] req_lvl;
	} tick_report_t;

	tick_report_t     tick_reports[$];

	logic [ID_W-1:0]  slot_ids[NUM_LEVELS][MAX_JOBS];
	int               queue_head[NUM_LEVELS];
	int               queue_len[NUM_LEVELS];
	logic [SVC_W-1:0] svc_need[MAX_JOBS];
	logic [SVC_W-1:0] served[MAX_JOBS];
	int               slice_len[NUM_LEVELS];
	logic             run_valid;
	logic [ID_W-1:0]  run_id;
	int               run_lvl;
	int               used;
	logic [TS_W-1:0]  base_slice;
	logic             exp_on;

	function automatic void rebuild_slices();
		int p;
		for (int lv = 0; lv < NUM_LEVELS; lv++) begin
			p = int'(base_slice);
			if (exp_on) begin
				p = 1;
				for (int k = 0; k < lv; k++) begin
					p = p * int'(base_slice);
					if (p > int'(SAT_TICKS))
						p = int'(SAT_TICKS);
				end
			end
			slice_len[lv] = p;
		end
	endfunction

	function automatic void clear_model();
		for (int lv = 0; lv < NUM_LEVELS; lv++) begin
			queue_head[lv] = 0;
			queue_len[lv]  = 0;
			for (int s = 0; s < MAX_JOBS; s++)
				slot_ids[lv][s] = '0;
		end
		for (int j = 0; j < MAX_JOBS; j++) begin
			svc_need[j] = '0;
			served[j]   = '0;
		end
		run_valid  = 1'b0;
		run_id     = '0;
		run_lvl    = 0;
		used       = 0;
		base_slice = TS_RST;
		exp_on     = 1'b0;
		rebuild_slices();
		tick_reports.delete();
	endfunction

	function automatic bit any_work();
		for (int lv = 0; lv < NUM_LEVELS; lv++)
			if (queue_len[lv] != 0)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void write_register(logic [0:0] idx, logic [CFG_W-1:0] data);
		case (cfg_idx_t'(idx))
			CFG_TIME_SLICE: begin
				base_slice = data[TS_W-1:0];
			end
			CFG_EXP_SLICES: begin
				exp_on = data[0];
			end
			default: ;
		endcase
		rebuild_slices();
	endfunction

	// Advances the scheduler by one accepted word; a tick queues the report it produces.
	function automatic void schedule_word(logic m, logic [ID_W-1:0] jid, logic [SVC_W-1:0] svc);
		tick_report_t rep;
		int           tgt;
		int           pos;
		if (m == MODE_ARRIVAL) begin
			// An arrival to a full top level leaves every piece of state untouched.
			if (queue_len[0] < MAX_JOBS) begin
				svc_need[jid % MAX_JOBS] = svc;
				served[jid % MAX_JOBS]   = '0;
				queue_head[0] = (queue_head[0] + MAX_JOBS - 1) % MAX_JOBS;
				slot_ids[0][queue_head[0]] = jid;
				queue_len[0]++;
			end
			return;
		end
		rep = '0;
		if (!run_valid) begin
			for (int lv = 0; lv < NUM_LEVELS; lv++) begin
				if (!run_valid && queue_len[lv] != 0) begin
					run_id = slot_ids[lv][queue_head[lv]];
					queue_head[lv] = (queue_head[lv] + 1) % MAX_JOBS;
					queue_len[lv]--;
					run_lvl   = lv;
					run_valid = 1'b1;
					used      = 0;
				end
			end
		end
		if (run_valid) begin
			rep.ran = 1'b1;
			rep.id  = run_id;
			rep.lvl = LVL_W'(run_lvl);
			if (served[run_id] < SAT_TICKS)
				served[run_id]++;
			if (used < int'(SAT_TICKS))
				used++;
			if (served[run_id] >= svc_need[run_id]) begin
				rep.fin   = 1'b1;
				run_valid = 1'b0;
				used      = 0;
			end else if (used >= slice_len[run_lvl]) begin
				tgt = run_lvl;
				if (any_work() && tgt != NUM_LEVELS - 1)
					tgt++;
				// A job whose target level is full is dropped.
				if (queue_len[tgt] < MAX_JOBS) begin
					pos = (queue_head[tgt] + queue_len[tgt]) % MAX_JOBS;
					slot_ids[tgt][pos] = run_id;
					queue_len[tgt]++;
					rep.req     = 1'b1;
					rep.req_lvl = LVL_W'(tgt);
				end
				run_valid = 1'b0;
				used      = 0;
			end
		end
		tick_reports.push_back(rep);
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void check_report();
		tick_report_t want;
		if (tick_reports.size() == 0) begin
			$error("result word with no tick outstanding: ran_valid %0d ran_id %0d",
				ran_valid, ran_id);
			fail_count++;
			return;
		end
		want = tick_reports.pop_front();
		compare_field("ran_valid", int'(want.ran), int'(ran_valid));
		compare_field("ran_id", int'(want.id), int'(ran_id));
		compare_field("ran_level", int'(want.lvl), int'(ran_level));
		compare_field("job_finished", int'(want.fin), int'(job_finished));
		compare_field("job_requeued", int'(want.req), int'(job_requeued));
		compare_field("requeue_level", int'(want.req_lvl), int'(requeue_level));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
		end else begin
			if (done)
				check_report();
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (start && !busy)
				schedule_word(mode, job_id, service_time);
		end
		pending = tick_reports.size();
	end

endmodule

[verif/mlfq_tick_scheduler_top_tb.sv]
module mlfq_tick_scheduler_top_tb;
	import mlfq_pkg::*;
	import mlfq_tick_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_LEVELS  = 4;
	localparam int MAX_JOBS    = 16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_WORDS = 165;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             mode;
	logic [ID_W-1:0]  job_id;
	logic [SVC_W-1:0] service_time;
	logic             done;
	logic             ran_valid;
	logic [ID_W-1:0]  ran_id;
	logic [LVL_W-1:0] ran_level;
	logic             job_finished;
	logic             job_requeued;
	logic [LVL_W-1:0] requeue_level;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [0:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int burst_left  = 0;

	always #10 clk = ~clk;

	mlfq_tick_scheduler_top #(
		.NUM_LEVELS(NUM_LEVELS),
		.MAX_JOBS  (MAX_JOBS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.job_id       (job_id),
		.service_time (service_time),
		.done         (done),
		.ran_valid    (ran_valid),
		.ran_id       (ran_id),
		.ran_level    (ran_level),
		.job_finished (job_finished),
		.job_requeued (job_requeued),
		.requeue_level(requeue_level),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	mlfq_tick_scheduler_checker #(
		.NUM_LEVELS(NUM_LEVELS),
		.MAX_JOBS  (MAX_JOBS)
	) sched_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.job_id       (job_id),
		.service_time (service_time),
		.done         (done),
		.ran_valid    (ran_valid),
		.ran_id       (ran_id),
		.ran_level    (ran_level),
		.job_finished (job_finished),
		.job_requeued (job_requeued),
		.requeue_level(requeue_level),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("mlfq_tick_scheduler_top regression: fail");
			$finish;
		end
	end

	// Bursts of back-to-back words are broken by random gaps with start low.
	task automatic send_word(mode_t m, logic [ID_W-1:0] id, logic [SVC_W-1:0] svc);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		burst_left--;
		start        <= 1'b1;
		mode         <= m;
		job_id       <= id;
		service_time <= svc;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic tick();
		send_word(MODE_TICK, ID_W'($urandom_range(0, 15)), SVC_W'($urandom_range(0, 4095)));
	endtask

	// Arrivals leave no result, so the task waits on past the last report to cover one still in flight.
	task automatic drain();
		start <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Writes both registers in turn; valid stays high between the two words.
	task automatic set_slices(logic [TS_W-1:0] ts, logic expo);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_TIME_SLICE;
		cfg_data  <= ts;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= CFG_EXP_SLICES;
		cfg_data  <= {3'($urandom_range(0, 7)), expo};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly short jobs so the queues drain, with a few long and zero-length ones.
	task automatic random_word();
		int               pick;
		logic [SVC_W-1:0] svc;
		pick = $urandom_range(0, 99);
		if (pick < 24) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				svc = '0;
			else if (pick < 7)
				svc = SVC_W'($urandom_range(0, 4095));
			else if (pick < 15)
				svc = SVC_W'($urandom_range(5, 40));
			else
				svc = SVC_W'($urandom_range(1, 4));
			send_word(MODE_ARRIVAL, ID_W'($urandom_range(0, 15)), svc);
		end else begin
			tick();
		end
	endtask

	initial begin
		logic [TS_W-1:0] phase_ts[8];
		logic            phase_exp[8];
		phase_ts  = '{4'd2, 4'd15, 4'd0, 4'd1, 4'd15, 4'd0, 4'd3, 4'd4};
		phase_exp = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
		phase_ts[7]  = TS_W'($urandom_range(0, 15));
		phase_exp[7] = 1'($urandom_range(0, 1));

		arst_n       = 1'b0;
		start        = 1'b0;
		mode         = MODE_ARRIVAL;
		job_id       = '0;
		service_time = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_TIME_SLICE;
		cfg_data     = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset slices: idle tick, zero service time, longest job and an id overwritten
		// while it is running.
		tick();
		send_word(MODE_ARRIVAL, 4'd15, 12'd0);
		tick();
		send_word(MODE_ARRIVAL, 4'd0, 12'hFFF);
		send_word(MODE_ARRIVAL, 4'd9, 12'd5);
		repeat (3) tick();
		send_word(MODE_ARRIVAL, 4'd0, 12'd1);
		repeat (8) tick();

		// One-tick slices: fill the top level, overflow it, push all sixteen down a level,
		// then demote one more job into the full level so it is dropped.
		set_slices(4'd1, 1'b0);
		for (int j = 0; j < MAX_JOBS; j++)
			send_word(MODE_ARRIVAL, ID_W'(j), 12'd3);
		send_word(MODE_ARRIVAL, 4'd7, 12'd2);
		repeat (MAX_JOBS) tick();
		send_word(MODE_ARRIVAL, 4'd3, 12'd5);
		tick();

		for (int ph = 0; ph < 8; ph++) begin
			set_slices(phase_ts[ph], phase_exp[ph]);
			repeat (PHASE_WORDS) random_word();
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("mlfq_tick_scheduler_top regression: pass");
		else
			$display("mlfq_tick_scheduler_top regression: fail");
		$finish;
	end

endmodule
